// ----- src/umsr_pkg.sv -----
package umsr_pkg;

  localparam int STORE_BYTES_DEF = 64;
  localparam int WRITE_CHUNK     = 16;
  localparam int CHUNK_W         = $clog2(WRITE_CHUNK);
  localparam int ADDR_W          = 19;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 7;

  // smallest closing sysex that carries a full write chunk
  localparam int WRITE_MIN_LEN   = 6 + 2 * WRITE_CHUNK;
  localparam int ERASE_MIN_LEN   = 6;
  localparam int FRAME_MIN_LEN   = 3;

  // usb-midi code indices
  localparam logic [3:0] CIN_SYSEX_CONT = 4'h4;
  localparam logic [3:0] CIN_SYSEX_END1 = 4'h5;
  localparam logic [3:0] CIN_SYSEX_END2 = 4'h6;
  localparam logic [3:0] CIN_SYSEX_END3 = 4'h7;
  localparam logic [3:0] CIN_SINGLE     = 4'hF;

  localparam logic [7:0] SX_HEAD_BYTE = 8'hF0;
  localparam logic [7:0] SX_TAIL_BYTE = 8'hF7;
  localparam logic [7:0] ERASE_KEY0   = 8'h42;
  localparam logic [7:0] ERASE_KEY1   = 8'h24;
  localparam logic [7:0] RT_CLOCK     = 8'hF8;
  localparam logic [7:0] RT_START     = 8'hFA;
  localparam logic [7:0] RT_STOP      = 8'hFC;

  // result actions
  localparam logic [1:0] ACT_REALTIME = 2'd0;
  localparam logic [1:0] ACT_ERASE    = 2'd1;
  localparam logic [1:0] ACT_WRITE    = 2'd2;
  localparam logic [1:0] ACT_RESET    = 2'd3;

  // configuration register indices
  localparam logic [CFG_IDX_W-1:0] REG_MFR_ID    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ERASE_CMD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_CMD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_CMD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RT_PASS   = 3'd4;

  localparam logic [6:0] MFR_ID_RST    = 7'd125;
  localparam logic [6:0] ERASE_CMD_RST = 7'd1;
  localparam logic [6:0] WRITE_CMD_RST = 7'd2;
  localparam logic [6:0] RESET_CMD_RST = 7'd3;

  typedef struct packed {
    logic [3:0] code_index;
    logic [7:0] data_a;
    logic [7:0] data_b;
    logic [7:0] data_c;
    logic       last_in_transfer;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [7:0]        out_byte;
    logic [ADDR_W-1:0] flash_address;
    logic              last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_write_t;

endpackage

// ----- src/umsr_if.sv -----
interface umsr_in_if import umsr_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface umsr_out_if import umsr_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface umsr_cfg_if import umsr_pkg::*; ();
  logic       valid;
  logic       ready;
  cfg_write_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/umsr_ram.sv -----
module umsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/usb_midi_sysex_command_receiver.sv -----
// USB-MIDI SysEx command receiver. Each input beat is one 4-byte event packet.
// SysEx packets (code index 4..7) are appended to a byte store; a closing packet
// checks the framing (F0, manufacturer id, command, ..., F7) and yields one
// erase result, one reset result, or sixteen write-byte results whose address
// is the 16-byte block offset plus the byte number. Single-byte packets pass
// clock, start and stop realtime bytes when enabled; unknown code indices drop
// the rest of the USB transfer. One packet is worked on at a time. Packets that
// only touch control state are handled in the idle state; a SysEx packet adds
// one store write per byte; a closing packet then reads the five header bytes
// and checks them; a realtime, erase or reset result goes through an emit state
// into the output register once it is free; a write walks the store result by
// result, each data byte taking two reads of the single store read port. A
// result waits in the output register while the next packet is taken.
module usb_midi_sysex_command_receiver import umsr_pkg::*; #(
  parameter int STORE_BYTES = STORE_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  umsr_in_if.sink    in_i,
  umsr_out_if.source out_o,
  umsr_cfg_if.sink   cfg_i
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int LW = $clog2(STORE_BYTES + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_APPEND = 3'd1;
  localparam logic [2:0] S_HDR    = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_DATA   = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0] state_q, state_d;
  logic [LW-1:0] len_q, len_d;
  logic skip_q, skip_d;
  logic [1:0] cnt_q, cnt_d;
  logic close_q, close_d;
  logic [2:0][7:0] pkt_q, pkt_d;
  logic [7:0] lastb_q, lastb_d;
  logic [1:0] k_q, k_d;
  logic [2:0] hidx_q, hidx_d;
  logic [4:0][7:0] hdr_q, hdr_d;
  logic [CHUNK_W-1:0] i_q, i_d;
  logic [1:0] ph_q, ph_d;
  logic [7:0] hi_q, hi_d;
  out_item_t pend_q, pend_d;
  out_item_t out_item_q, out_next;
  logic out_valid_q, out_load, out_free;

  logic [6:0] mfr_q, erase_q, write_q, reset_q;
  logic rt_q;

  logic mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0] mem_wdata, mem_rdata;

  in_item_t in_d;
  logic accept;
  logic [1:0] in_cnt;
  logic [7:0] in_lastb;
  logic [LW:0] fill_sum;
  logic [7:0] st0, st1, st2, st3, st4;
  logic frame_ok;
  logic [14:0] block_base;

  umsr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_d      = in_i.data;
  assign in_i.ready = (state_q == S_IDLE);
  assign accept    = in_i.valid && (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;
  assign out_free  = !out_valid_q || out_o.ready;

  // header bytes are shifted in, so store byte 0 ends up on top
  assign st0 = hdr_q[4];
  assign st1 = hdr_q[3];
  assign st2 = hdr_q[2];
  assign st3 = hdr_q[1];
  assign st4 = hdr_q[0];
  assign block_base = {st3, 7'd0} | {7'd0, st4};

  assign fill_sum = {1'b0, len_q} + (LW+1)'(in_cnt);

  always_comb begin
    in_cnt   = 2'd0;
    in_lastb = in_d.data_c;
    case (in_d.code_index)
      CIN_SYSEX_CONT: in_cnt = 2'd3;
      CIN_SYSEX_END1: begin
        in_cnt   = 2'd1;
        in_lastb = in_d.data_a;
      end
      CIN_SYSEX_END2: begin
        in_cnt   = 2'd2;
        in_lastb = in_d.data_b;
      end
      CIN_SYSEX_END3: in_cnt = 2'd3;
      default: in_cnt = 2'd0;
    endcase
  end

  assign frame_ok = (len_q >= LW'(FRAME_MIN_LEN)) && (st0 == SX_HEAD_BYTE) &&
                    (lastb_q == SX_TAIL_BYTE) && (st1 == {1'b0, mfr_q});

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    skip_d   = skip_q;
    cnt_d    = cnt_q;
    close_d  = close_q;
    pkt_d    = pkt_q;
    lastb_d  = lastb_q;
    k_d      = k_q;
    hidx_d   = hidx_q;
    hdr_d    = hdr_q;
    i_d      = i_q;
    ph_d     = ph_q;
    hi_d     = hi_q;
    pend_d   = pend_q;
    out_load = 1'b0;
    out_next = pend_q;
    mem_we    = 1'b0;
    mem_waddr = AW'(len_q + LW'(k_q));
    mem_wdata = pkt_q[0];
    mem_re    = 1'b0;
    mem_raddr = '0;

    case (k_q)
      2'd0:    mem_wdata = pkt_q[0];
      2'd1:    mem_wdata = pkt_q[1];
      default: mem_wdata = pkt_q[2];
    endcase

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (skip_q) begin
            if (in_d.last_in_transfer) begin
              skip_d = 1'b0;
            end
          end else begin
            if (in_cnt == 2'd0) begin
              len_d = '0;
            end
            if (in_cnt != 2'd0) begin
              if (fill_sum > (LW+1)'(STORE_BYTES)) begin
                len_d = '0;
              end else begin
                cnt_d   = in_cnt;
                close_d = (in_d.code_index != CIN_SYSEX_CONT);
                pkt_d   = {in_d.data_c, in_d.data_b, in_d.data_a};
                lastb_d = in_lastb;
                k_d     = 2'd0;
                state_d = S_APPEND;
              end
            end else if (in_d.code_index == CIN_SINGLE) begin
              if (rt_q && (in_d.data_a == RT_CLOCK || in_d.data_a == RT_START ||
                           in_d.data_a == RT_STOP)) begin
                pend_d.action        = ACT_REALTIME;
                pend_d.out_byte      = in_d.data_a;
                pend_d.flash_address = '0;
                pend_d.last_of_run   = 1'b1;
                state_d = S_EMIT;
              end
            end else if (!in_d.last_in_transfer) begin
              skip_d = 1'b1;
            end
          end
        end
      end
      S_APPEND: begin
        mem_we = 1'b1;
        if (k_q == cnt_q - 2'd1) begin
          len_d = len_q + LW'(cnt_q);
          if (close_q) begin
            hidx_d  = 3'd0;
            state_d = S_HDR;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      S_HDR: begin
        // read bytes 0..4, each captured in the cycle after its read
        if (hidx_q != 3'd5) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(hidx_q);
        end
        if (hidx_q != 3'd0) begin
          hdr_d = {hdr_q[3:0], mem_rdata};
        end
        hidx_d = hidx_q + 3'd1;
        if (hidx_q == 3'd5) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        len_d   = '0;
        state_d = S_IDLE;
        pend_d.out_byte      = '0;
        pend_d.flash_address = '0;
        pend_d.last_of_run   = 1'b1;
        if (frame_ok) begin
          if (st2 == {1'b0, erase_q}) begin
            if (len_q >= LW'(ERASE_MIN_LEN) && st3 == ERASE_KEY0 && st4 == ERASE_KEY1) begin
              pend_d.action = ACT_ERASE;
              state_d = S_EMIT;
            end
          end else if (st2 == {1'b0, write_q}) begin
            if (len_q >= LW'(WRITE_MIN_LEN)) begin
              i_d     = '0;
              ph_d    = 2'd0;
              state_d = S_DATA;
            end
          end else if (st2 == {1'b0, reset_q}) begin
            pend_d.action = ACT_RESET;
            state_d = S_EMIT;
          end
        end
      end
      S_DATA: begin
        case (ph_q)
          2'd0: begin
            mem_re    = 1'b1;
            mem_raddr = AW'({i_q, 1'b0}) + AW'(5);
            ph_d      = 2'd1;
          end
          2'd1: begin
            hi_d      = mem_rdata;
            mem_re    = 1'b1;
            mem_raddr = AW'({i_q, 1'b0}) + AW'(6);
            ph_d      = 2'd2;
          end
          default: begin
            // low byte stays on the read port until the output frees up
            if (out_free) begin
              out_load               = 1'b1;
              out_next.action        = ACT_WRITE;
              out_next.out_byte      = {hi_q[3:0], 4'd0} | mem_rdata;
              out_next.flash_address = {block_base, i_q};
              out_next.last_of_run   = (i_q == CHUNK_W'(WRITE_CHUNK - 1));
              ph_d = 2'd0;
              if (i_q == CHUNK_W'(WRITE_CHUNK - 1)) begin
                state_d = S_IDLE;
              end else begin
                i_d = i_q + CHUNK_W'(1);
              end
            end
          end
        endcase
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      skip_q      <= 1'b0;
      out_valid_q <= 1'b0;
      mfr_q       <= MFR_ID_RST;
      erase_q     <= ERASE_CMD_RST;
      write_q     <= WRITE_CMD_RST;
      reset_q     <= RESET_CMD_RST;
      rt_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      skip_q  <= skip_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        case (cfg_i.data.index)
          REG_MFR_ID:    mfr_q   <= cfg_i.data.data;
          REG_ERASE_CMD: erase_q <= cfg_i.data.data;
          REG_WRITE_CMD: write_q <= cfg_i.data.data;
          REG_RESET_CMD: reset_q <= cfg_i.data.data;
          REG_RT_PASS:   rt_q    <= cfg_i.data.data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    close_q <= close_d;
    pkt_q   <= pkt_d;
    lastb_q <= lastb_d;
    k_q     <= k_d;
    hidx_q  <= hidx_d;
    hdr_q   <= hdr_d;
    i_q     <= i_d;
    ph_q    <= ph_d;
    hi_q    <= hi_d;
    pend_q  <= pend_d;
    if (out_load) begin
      out_item_q <= out_next;
    end
  end

endmodule
